@@ hw/rtl/fsbs_pkg.sv @@
package fsbs_pkg;

   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DISP = 2'd1;
   localparam logic [1:0] CMD_DONE = 2'd2;

   localparam logic [2:0] ST_ENQ   = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_DISP  = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;
   localparam logic [2:0] ST_IGN   = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ENQ_INS,
      S_SLOT_SCAN,
      S_CHARGE,
      S_ROOT_CHECK,
      S_EXTRACT,
      S_SDN_CMP,
      S_SUP_CMP,
      S_FINISH,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      RET_ENQ,
      RET_SCAN,
      RET_ROOT,
      RET_DONE
   } ret_type;

endpackage

@@ hw/rtl/fsbs_sat_add.sv @@
module fsbs_sat_add import fsbs_pkg::*; #(
   parameter int TIME_BITS = 48
) (
   input  logic [TIME_BITS-1:0] base,
   input  logic [TIME_BITS-1:0] now_val,
   input  logic [TIME_BITS-1:0] since,
   output logic [TIME_BITS-1:0] sum
);

   logic [TIME_BITS-1:0] dur;
   logic [TIME_BITS:0]   wide;

   always_comb begin
      dur  = now_val - since;
      wide = {1'b0, base} + {1'b0, dur};
      sum  = wide[TIME_BITS] ? {TIME_BITS{1'b1}} : wide[TIME_BITS-1:0];
   end

endmodule

@@ hw/rtl/fair_share_bucket_scheduler_top.sv @@
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_cmd, req_bucket_id, req_thread_slot, req_now
// rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_served_bucket, rsp_pending_left
// A sift repeats a compare-and-swap state and ends with a compare that finds no swap.
// Enqueue passes through a decode state; a new bucket adds an insert state and a sift up.
// Dispatch to a free slot visits every slot, with a sift down per charged bucket, then checks
// the root and spends an extract state plus a sift down per removed root.
// A stalled response holds; the next word is taken only in the idle state after the response has left.
// Reset is synchronous and clears heap count, membership, pending counts and busy slots.
module fair_share_bucket_scheduler_top import fsbs_pkg::*; #(
   parameter int BUCKETS     = 32,
   parameter int THREADS     = 8,
   parameter int MAX_PENDING = 65535,
   parameter int TIME_BITS   = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_bucket_id,
   input  logic [2:0]  req_thread_slot,
   input  logic [47:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_served_bucket,
   output logic [15:0] rsp_pending_left
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int CW = $clog2(BUCKETS + 1);
   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int PW = $clog2(MAX_PENDING + 1);
   localparam logic [PW-1:0] PMAX = PW'(MAX_PENDING);

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;

   logic [BW-1:0]        hb_ff [BUCKETS];
   logic [TIME_BITS-1:0] hx_ff [BUCKETS];
   logic [BW-1:0]        pos_ff [BUCKETS];
   logic [BUCKETS-1:0]   inh_ff;
   logic [PW-1:0]        pend_ff [BUCKETS];
   logic [THREADS-1:0]   busy_ff;
   logic [BW-1:0]        sb_ff [THREADS];
   logic [TIME_BITS-1:0] sacc_ff [THREADS];
   logic [CW-1:0]        cnt_ff;

   logic [1:0]           cmd_ff;
   logic [BW-1:0]        bid_ff;
   logic [TW-1:0]        slot_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TW:0]          scan_ff;
   logic [BW-1:0]        p_ff;
   logic [2:0]           st_ff;
   logic [4:0]           sv_ff;
   logic [15:0]          lf_ff;

   logic [TIME_BITS-1:0] add_base, add_since, add_sum;

   fsbs_sat_add #(.TIME_BITS(TIME_BITS)) u_add (
      .base(add_base), .now_val(now_ff), .since(add_since), .sum(add_sum));

   // Heap index arithmetic on the current position, plus adder inputs and decode flags.
   logic [CW:0]   lft, rgt;
   logic [BW-1:0] li, ri, chi, par;
   logic          has_l, has_r, pick_r;
   logic [BW-1:0] sb_cur, root_b, cur_b;
   logic [CW-1:0] last_w;
   logic [BW-1:0] last_i;
   logic          req_ok, sup_swap, sdn_swap, scan_done, enq_full, enq_ins;

   always_comb begin
      lft    = {p_ff, 1'b1} + (CW+1)'(0);
      rgt    = lft + 1'b1;
      li     = lft[BW-1:0];
      ri     = rgt[BW-1:0];
      has_l  = lft < (CW+1)'(cnt_ff);
      has_r  = rgt < (CW+1)'(cnt_ff);
      pick_r = has_r && (hx_ff[ri] < hx_ff[li]);
      chi    = pick_r ? ri : li;
      par    = BW'((p_ff - 1'b1) >> 1);
      sb_cur = sb_ff[scan_ff[TW-1:0]];
      root_b = hb_ff[0];
      cur_b  = sb_ff[slot_ff];
      last_w = cnt_ff - 1'b1;
      last_i = last_w[BW-1:0];
      add_base  = hx_ff[pos_ff[sb_cur]];
      add_since = sacc_ff[scan_ff[TW-1:0]];
      if (cmd_ff == CMD_DONE) begin
         add_base  = hx_ff[pos_ff[cur_b]];
         add_since = sacc_ff[slot_ff];
      end
      req_ok    = (req_cmd == CMD_ENQ && 32'(req_bucket_id) < BUCKETS) ||
                  ((req_cmd == CMD_DISP || req_cmd == CMD_DONE) &&
                   32'(req_thread_slot) < THREADS);
      sup_swap  = (p_ff != '0) && (hx_ff[p_ff] < hx_ff[par]);
      sdn_swap  = has_l && (hx_ff[chi] < hx_ff[p_ff]);
      scan_done = (scan_ff == (TW+1)'(THREADS));
      enq_full  = (pend_ff[bid_ff] >= PMAX);
      enq_ins   = !inh_ff[bid_ff] && (cnt_ff < CW'(BUCKETS));
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_served_bucket = sv_ff;
   assign rsp_pending_left = lf_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = req_ok ? S_DECODE : S_OUT;
         end
         S_DECODE: begin
            case (cmd_ff)
               CMD_ENQ: state_in = (!enq_full && enq_ins) ? S_ENQ_INS : S_OUT;
               CMD_DISP: begin
                  if (busy_ff[slot_ff]) state_in = S_OUT;
                  else begin
                     ret_in   = RET_SCAN;
                     state_in = S_SLOT_SCAN;
                  end
               end
               CMD_DONE: begin
                  if (busy_ff[slot_ff] && inh_ff[cur_b]) begin
                     ret_in   = RET_DONE;
                     state_in = S_SDN_CMP;
                  end else state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_ENQ_INS: state_in = S_SUP_CMP;
         S_SUP_CMP: begin
            if (!sup_swap) state_in = S_OUT;
         end
         S_SLOT_SCAN: begin
            if (scan_done) state_in = S_ROOT_CHECK;
            else if (busy_ff[scan_ff[TW-1:0]] && inh_ff[sb_cur]) begin
               ret_in   = RET_SCAN;
               state_in = S_SDN_CMP;
            end
         end
         S_ROOT_CHECK: begin
            if (cnt_ff == '0 || pend_ff[root_b] != '0) state_in = S_OUT;
            else state_in = S_EXTRACT;
         end
         S_EXTRACT: begin
            ret_in   = RET_ROOT;
            state_in = S_SDN_CMP;
         end
         S_SDN_CMP: begin
            if (!sdn_swap) begin
               case (ret_ff)
                  RET_SCAN: state_in = S_SLOT_SCAN;
                  RET_ROOT: state_in = S_ROOT_CHECK;
                  default:  state_in = S_OUT;
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_DONE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         inh_ff   <= '0;
         busy_ff  <= '0;
         for (int i = 0; i < BUCKETS; i++) pend_ff[i] <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  bid_ff   <= BW'(req_bucket_id);
                  slot_ff  <= TW'(req_thread_slot);
                  now_ff   <= TIME_BITS'(req_now);
                  scan_ff  <= '0;
                  st_ff    <= ST_IGN;
                  sv_ff    <= '0;
                  lf_ff    <= '0;
               end
            end
            S_DECODE: begin
               case (cmd_ff)
                  CMD_ENQ: begin
                     sv_ff <= 5'(bid_ff);
                     if (enq_full) begin
                        st_ff    <= ST_FULL;
                        lf_ff    <= 16'(pend_ff[bid_ff]);
                     end else begin
                        pend_ff[bid_ff] <= pend_ff[bid_ff] + 1'b1;
                        st_ff    <= ST_ENQ;
                        lf_ff    <= 16'(pend_ff[bid_ff] + 1'b1);
                     end
                  end
                  CMD_DONE: begin
                     if (busy_ff[slot_ff]) begin
                        busy_ff[slot_ff] <= 1'b0;
                        st_ff    <= ST_DONE;
                        sv_ff    <= 5'(cur_b);
                        lf_ff    <= 16'(pend_ff[cur_b]);
                        if (inh_ff[cur_b]) begin
                           hx_ff[pos_ff[cur_b]] <= add_sum;
                           p_ff     <= pos_ff[cur_b];
                        end
                     end
                  end
                  default: ;
               endcase
            end
            S_ENQ_INS: begin
               hx_ff[cnt_ff[BW-1:0]] <= (cnt_ff != '0) ? hx_ff[0] : '0;
               hb_ff[cnt_ff[BW-1:0]] <= bid_ff;
               pos_ff[bid_ff]        <= cnt_ff[BW-1:0];
               inh_ff[bid_ff]        <= 1'b1;
               cnt_ff   <= cnt_ff + 1'b1;
               p_ff     <= cnt_ff[BW-1:0];
            end
            S_SUP_CMP: begin
               if (sup_swap) begin
                  hb_ff[p_ff] <= hb_ff[par];
                  hx_ff[p_ff] <= hx_ff[par];
                  hb_ff[par]  <= hb_ff[p_ff];
                  hx_ff[par]  <= hx_ff[p_ff];
                  pos_ff[hb_ff[par]]  <= p_ff;
                  pos_ff[hb_ff[p_ff]] <= par;
                  p_ff <= par;
               end
            end
            S_SLOT_SCAN: begin
               if (!scan_done) begin
                  scan_ff <= scan_ff + 1'b1;
                  if (busy_ff[scan_ff[TW-1:0]]) begin
                     sacc_ff[scan_ff[TW-1:0]] <= now_ff;
                     if (inh_ff[sb_cur]) begin
                        hx_ff[pos_ff[sb_cur]] <= add_sum;
                        p_ff     <= pos_ff[sb_cur];
                     end
                  end
               end
            end
            S_ROOT_CHECK: begin
               if (cnt_ff == '0) begin
                  st_ff    <= ST_EMPTY;
               end else if (pend_ff[root_b] != '0) begin
                  pend_ff[root_b]  <= pend_ff[root_b] - 1'b1;
                  busy_ff[slot_ff] <= 1'b1;
                  sb_ff[slot_ff]   <= root_b;
                  sacc_ff[slot_ff] <= now_ff;
                  st_ff    <= ST_DISP;
                  sv_ff    <= 5'(root_b);
                  lf_ff    <= 16'(pend_ff[root_b] - 1'b1);
               end
            end
            S_EXTRACT: begin
               hb_ff[0]      <= hb_ff[last_i];
               hx_ff[0]      <= hx_ff[last_i];
               hb_ff[last_i] <= hb_ff[0];
               hx_ff[last_i] <= hx_ff[0];
               pos_ff[hb_ff[last_i]] <= '0;
               pos_ff[hb_ff[0]]      <= last_i;
               inh_ff[hb_ff[0]]      <= 1'b0;
               cnt_ff   <= last_w;
               p_ff     <= '0;
            end
            S_SDN_CMP: begin
               if (sdn_swap) begin
                  hb_ff[p_ff] <= hb_ff[chi];
                  hx_ff[p_ff] <= hx_ff[chi];
                  hb_ff[chi]  <= hb_ff[p_ff];
                  hx_ff[chi]  <= hx_ff[p_ff];
                  pos_ff[hb_ff[chi]]  <= p_ff;
                  pos_ff[hb_ff[p_ff]] <= chi;
                  p_ff <= chi;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

@@ hw/rtl/fsbs_checker.sv @@
module fsbs_checker import fsbs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_served_bucket,
   input logic [15:0] rsp_pending_left
);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while word pending");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_IGN) else $error("bad status");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_IGN) |->
      rsp_served_bucket == 5'd0 && rsp_pending_left == 16'd0) else $error("nonzero fields");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)) else $error("word dropped");

endmodule

bind fair_share_bucket_scheduler_top fsbs_checker u_chk (.*);
